>>> rtl/core/triangle_face_normal_unit_core_defines.svh
// Shared assertion macros for the face normal core checkers.
`ifndef TRIANGLE_FACE_NORMAL_UNIT_CORE_DEFINES_SVH
`define TRIANGLE_FACE_NORMAL_UNIT_CORE_DEFINES_SVH

// Condition holds in the same cycle as the trigger.
`define TFN_ASSERT_NOW(name, trig, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error(msg);

// Condition holds in the cycle after the trigger.
`define TFN_ASSERT_NEXT(name, trig, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);

`endif

>>> rtl/core/tfn_pkg.sv
package tfn_pkg;

  localparam int COORD_WIDTH      = 24;
  localparam int NORMAL_FRAC_BITS = 14;
  localparam int NUM_COORDS       = 9;
  localparam int OUT_W            = 16;
  localparam int OUT_MAX          = 32767;
  localparam int Q_W              = 31;
  localparam int SUM_W            = 64;
  localparam int LEN_W            = 32;

  // Largest magnitude allowed on an output component.
  function automatic int norm_limit(input int frac_bits);
    int l;
    l = 1 << frac_bits;
    if (l > OUT_MAX) l = OUT_MAX;
    return l;
  endfunction

endpackage

>>> rtl/core/triangle_face_normal_unit_core.sv
// Triangle face normal core.
// Input channel (in_*): one triangle per item, nine signed vertex coordinates
// A, B, C packed in in_tdata. Output channel (out_*): one unit normal per
// triangle, three signed components with NORMAL_FRAC_BITS fraction bits in
// out_tdata, and a degenerate flag in out_tuser (components then zero).
// Throughput: one triangle per cycle while the receiver does not stall.
// Pipeline: 8 front stages (difference, products, cross, magnitude, leading
// zero count, normalize, square, sum), 33 square root stages, NORMAL_FRAC_BITS
// + 2 division stages and one output register.
// The square root and divider are pipelined one bit per stage, which sets the
// depth.
// Reset clears all valid bits; the pipeline empties and out_tvalid drops.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_tready goes low; nothing is lost or repeated.
module triangle_face_normal_unit_core #(
  parameter int COORD_WIDTH      = tfn_pkg::COORD_WIDTH,
  parameter int NORMAL_FRAC_BITS = tfn_pkg::NORMAL_FRAC_BITS
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_tvalid,
  output logic                                      in_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z from bit 0 up, zero padded
  input  logic [((tfn_pkg::NUM_COORDS*COORD_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic                                      out_tvalid,
  input  logic                                      out_tready,
  // normal_x, normal_y, normal_z from bit 0 up
  output logic [3*tfn_pkg::OUT_W-1:0]               out_tdata,
  // degenerate
  output logic [0:0]                                out_tuser
);

  localparam int W    = COORD_WIDTH;
  localparam int D    = W + 1;
  localparam int PW   = 2 * D;
  localparam int CW   = PW + 1;
  localparam int QW   = tfn_pkg::Q_W;
  localparam int LZ_W = $clog2(CW + 1);
  localparam int F    = NORMAL_FRAC_BITS;
  localparam int LIM  = tfn_pkg::norm_limit(NORMAL_FRAC_BITS);
  localparam int SIDE_W = 3 * QW + 4;

  logic en;

  // Stage 1: edge vectors u = C - B, v = A - B.
  logic signed [2:0][D-1:0] u_r, v_r;
  logic                     v1_r;
  // Stage 2: six products.
  logic signed [5:0][PW-1:0] p_r;
  logic                      v2_r;
  // Stage 3: cross product.
  logic signed [2:0][CW-1:0] cr_r;
  logic                      v3_r;
  // Stage 4: magnitudes and signs.
  logic [2:0][CW-1:0] m4_r;
  logic [2:0]         neg4_r;
  logic               v4_r;
  // Stage 5: leading zero count of the largest magnitude.
  logic [2:0][CW-1:0] m5_r;
  logic [2:0]         neg5_r;
  logic [LZ_W-1:0]    lz_r;
  logic               dg5_r;
  logic               v5_r;
  // Stage 6: normalized magnitudes.
  logic [2:0][QW-1:0] q6_r;
  logic [2:0]         neg6_r;
  logic               dg6_r;
  logic               v6_r;
  // Stage 7: squares.
  logic [2:0][2*QW-1:0] sq_r;
  logic [2:0][QW-1:0]   q7_r;
  logic [2:0]           neg7_r;
  logic                 dg7_r;
  logic                 v7_r;
  // Stage 8: sum of squares.
  logic [tfn_pkg::SUM_W-1:0] sum_r;
  logic [2:0][QW-1:0]        q8_r;
  logic [2:0]                neg8_r;
  logic                      dg8_r;
  logic                      v8_r;

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  logic signed [2:0][D-1:0] u_nxt, v_nxt;
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      u_nxt[c] = $signed({in_tdata[(6+c)*W+W-1], in_tdata[(6+c)*W +: W]})
               - $signed({in_tdata[(3+c)*W+W-1], in_tdata[(3+c)*W +: W]});
      v_nxt[c] = $signed({in_tdata[c*W+W-1], in_tdata[c*W +: W]})
               - $signed({in_tdata[(3+c)*W+W-1], in_tdata[(3+c)*W +: W]});
    end
  end

  logic [CW-1:0]   mor;
  logic [LZ_W-1:0] lz_nxt;
  assign mor = m4_r[0] | m4_r[1] | m4_r[2];
  always_comb begin
    lz_nxt = LZ_W'(CW);
    for (int i = 0; i < CW; i++) begin
      if (mor[i]) lz_nxt = LZ_W'(CW - 1 - i);
    end
  end

  logic [2:0][CW+QW-1:0] ext;
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      ext[c] = {m5_r[c], {QW{1'b0}}} << lz_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
      v8_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u_r <= u_nxt;
      v_r <= v_nxt;

      p_r[0] <= $signed(u_r[1]) * $signed(v_r[2]);
      p_r[1] <= $signed(u_r[2]) * $signed(v_r[1]);
      p_r[2] <= $signed(u_r[2]) * $signed(v_r[0]);
      p_r[3] <= $signed(u_r[0]) * $signed(v_r[2]);
      p_r[4] <= $signed(u_r[0]) * $signed(v_r[1]);
      p_r[5] <= $signed(u_r[1]) * $signed(v_r[0]);

      for (int c = 0; c < 3; c++) begin
        cr_r[c] <= CW'($signed(p_r[2*c])) - CW'($signed(p_r[2*c+1]));
      end

      for (int c = 0; c < 3; c++) begin
        neg4_r[c] <= cr_r[c][CW-1];
        m4_r[c]   <= cr_r[c][CW-1] ? CW'(-cr_r[c]) : CW'(cr_r[c]);
      end

      m5_r   <= m4_r;
      neg5_r <= neg4_r;
      lz_r   <= lz_nxt;
      dg5_r  <= (mor == '0);

      for (int c = 0; c < 3; c++) begin
        q6_r[c] <= ext[c][CW+QW-1 -: QW];
      end
      neg6_r <= neg5_r;
      dg6_r  <= dg5_r;

      for (int c = 0; c < 3; c++) begin
        sq_r[c] <= q6_r[c] * q6_r[c];
      end
      q7_r   <= q6_r;
      neg7_r <= neg6_r;
      dg7_r  <= dg6_r;

      sum_r  <= tfn_pkg::SUM_W'(sq_r[0]) + tfn_pkg::SUM_W'(sq_r[1])
              + tfn_pkg::SUM_W'(sq_r[2]);
      q8_r   <= q7_r;
      neg8_r <= neg7_r;
      dg8_r  <= dg7_r;
    end
  end

  logic                      sq_valid;
  logic [tfn_pkg::LEN_W-1:0] sq_root;
  logic [SIDE_W-1:0]         sq_side;

  tfn_sqrt_pipe #(
    .SIDE_W (SIDE_W)
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v8_r),
    .in_rad    (sum_r),
    .in_side   ({q8_r, neg8_r, dg8_r}),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  logic               dv_valid;
  logic [2:0][F:0]    dv_quot;
  logic [3:0]         dv_side;

  // A degenerate item carries len 0; its quotient is discarded below.
  tfn_div_pipe #(
    .FRAC   (F),
    .SIDE_W (4)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sq_valid),
    .in_len    (sq_root),
    .in_q      (sq_side[SIDE_W-1:4]),
    .in_side   (sq_side[3:0]),
    .out_valid (dv_valid),
    .out_quot  (dv_quot),
    .out_side  (dv_side)
  );

  logic                          out_valid_r;
  logic [2:0][tfn_pkg::OUT_W-1:0] norm_r;
  logic                          dg_r;
  logic [2:0][tfn_pkg::OUT_W-1:0] norm_nxt;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      logic [F:0]               n;
      logic [tfn_pkg::OUT_W-1:0] n16;
      n   = (dv_quot[c] > (F+1)'(LIM)) ? (F+1)'(LIM) : dv_quot[c];
      n16 = tfn_pkg::OUT_W'(n);
      if (dv_side[0]) begin
        norm_nxt[c] = '0;
      end else begin
        norm_nxt[c] = dv_side[1+c] ? -n16 : n16;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // side packs neg as {neg[2], neg[1], neg[0]} above the degenerate bit
      norm_r <= norm_nxt;
      dg_r   <= dv_side[0];
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = norm_r;
  assign out_tuser[0] = dg_r;

endmodule

>>> rtl/core/tfn_sqrt_pipe.sv
module tfn_sqrt_pipe #(
  parameter int SIDE_W = 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [tfn_pkg::SUM_W-1:0]   in_rad,
  input  logic [SIDE_W-1:0]           in_side,
  output logic                        out_valid,
  output logic [tfn_pkg::LEN_W-1:0]   out_root,
  output logic [SIDE_W-1:0]           out_side
);

  localparam int STEPS = tfn_pkg::SUM_W / 2;

  logic [tfn_pkg::SUM_W-1:0] v_r   [0:STEPS];
  logic [tfn_pkg::SUM_W-1:0] res_r [0:STEPS];
  logic [SIDE_W-1:0]         side_r[0:STEPS];
  logic                      vld_r [0:STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r[0]    <= in_rad;
      res_r[0]  <= '0;
      side_r[0] <= in_side;
    end
  end

  // One result bit per stage, two radicand bits consumed each step.
  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam logic [tfn_pkg::SUM_W-1:0] BIT =
      tfn_pkg::SUM_W'(1) << (tfn_pkg::SUM_W - 2 - 2 * k);
    logic [tfn_pkg::SUM_W-1:0] trial;
    assign trial = res_r[k] + BIT;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[k+1] <= side_r[k];
        if (v_r[k] >= trial) begin
          v_r[k+1]   <= v_r[k] - trial;
          res_r[k+1] <= (res_r[k] >> 1) + BIT;
        end else begin
          v_r[k+1]   <= v_r[k];
          res_r[k+1] <= res_r[k] >> 1;
        end
      end
    end
  end

  assign out_valid = vld_r[STEPS];
  assign out_root  = res_r[STEPS][tfn_pkg::LEN_W-1:0];
  assign out_side  = side_r[STEPS];

endmodule

>>> rtl/core/tfn_div_pipe.sv
module tfn_div_pipe #(
  parameter int FRAC   = tfn_pkg::NORMAL_FRAC_BITS,
  parameter int SIDE_W = 1
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  en,
  input  logic                                  in_valid,
  input  logic [tfn_pkg::LEN_W-1:0]             in_len,
  input  logic [2:0][tfn_pkg::Q_W-1:0]          in_q,
  input  logic [SIDE_W-1:0]                     in_side,
  output logic                                  out_valid,
  output logic [2:0][FRAC:0]                    out_quot,
  output logic [SIDE_W-1:0]                     out_side
);

  localparam int QB = FRAC + 1;
  localparam int NW = tfn_pkg::Q_W + FRAC + 1;

  logic [tfn_pkg::LEN_W-1:0]      len_r [0:QB];
  logic [2:0][tfn_pkg::LEN_W-1:0] rem_r [0:QB];
  logic [2:0][QB-1:0]             low_r [0:QB];
  logic [SIDE_W-1:0]              side_r[0:QB];
  logic                           vld_r [0:QB];

  // Numerator with rounding term: q * 2^FRAC + len/2.
  logic [2:0][NW-1:0] num;
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      num[c] = NW'({in_q[c], {FRAC{1'b0}}}) + NW'(in_len >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      len_r[0]  <= in_len;
      side_r[0] <= in_side;
      for (int c = 0; c < 3; c++) begin
        rem_r[0][c] <= tfn_pkg::LEN_W'(num[c][NW-1:QB]);
        low_r[0][c] <= num[c][QB-1:0];
      end
    end
  end

  // Restoring division, one quotient bit per stage; quotient shifts into low.
  for (genvar k = 0; k < QB; k++) begin : g_step
    logic [2:0][tfn_pkg::LEN_W:0] t;
    always_comb begin
      for (int c = 0; c < 3; c++) begin
        t[c] = {rem_r[k][c], low_r[k][c][QB-1]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        len_r[k+1]  <= len_r[k];
        side_r[k+1] <= side_r[k];
        for (int c = 0; c < 3; c++) begin
          if (t[c] >= {1'b0, len_r[k]}) begin
            rem_r[k+1][c] <= tfn_pkg::LEN_W'(t[c] - {1'b0, len_r[k]});
            low_r[k+1][c] <= {low_r[k][c][QB-2:0], 1'b1};
          end else begin
            rem_r[k+1][c] <= t[c][tfn_pkg::LEN_W-1:0];
            low_r[k+1][c] <= {low_r[k][c][QB-2:0], 1'b0};
          end
        end
      end
    end
  end

  assign out_valid = vld_r[QB];
  assign out_quot  = low_r[QB];
  assign out_side  = side_r[QB];

endmodule

>>> rtl/core/tfn_checker.sv
`include "triangle_face_normal_unit_core_defines.svh"

module tfn_checker #(
  parameter int COORD_WIDTH      = tfn_pkg::COORD_WIDTH,
  parameter int NORMAL_FRAC_BITS = tfn_pkg::NORMAL_FRAC_BITS
) (
  input logic                                      clk,
  input logic                                      rst_n,
  input logic                                      in_tvalid,
  input logic                                      in_tready,
  input logic [((tfn_pkg::NUM_COORDS*COORD_WIDTH+7)/8)*8-1:0] in_tdata,
  input logic                                      out_tvalid,
  input logic                                      out_tready,
  input logic [3*tfn_pkg::OUT_W-1:0]               out_tdata,
  input logic [0:0]                                out_tuser
);

  localparam int LIM = tfn_pkg::norm_limit(NORMAL_FRAC_BITS);

  logic signed [tfn_pkg::OUT_W-1:0] nx, ny, nz;
  assign nx = $signed(out_tdata[15:0]);
  assign ny = $signed(out_tdata[31:16]);
  assign nz = $signed(out_tdata[47:32]);

  `TFN_ASSERT_NEXT(a_in_hold, in_tvalid && !in_tready, in_tvalid && $stable(in_tdata), "input item changed while waiting")
  `TFN_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "result dropped while stalled")
  `TFN_ASSERT_NOW(a_stall_blocks_in, out_tvalid && !out_tready, !in_tready, "input taken during stall")
  `TFN_ASSERT_NOW(a_degen_zero, out_tvalid && out_tuser[0], out_tdata == '0, "degenerate result not zero")
  `TFN_ASSERT_NOW(a_norm_bound, out_tvalid && !out_tuser[0], (nx <= LIM) && (nx >= -LIM) && (ny <= LIM) && (ny >= -LIM) && (nz <= LIM) && (nz >= -LIM), "component out of range")

endmodule

bind triangle_face_normal_unit_core tfn_checker #(
  .COORD_WIDTH      (COORD_WIDTH),
  .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
) u_tfn_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

>>> tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = tfn_pkg::COORD_WIDTH;
  localparam int DW = ((tfn_pkg::NUM_COORDS * CW + 7) / 8) * 8;
  localparam int OW = tfn_pkg::OUT_W;
  localparam int FB = tfn_pkg::NORMAL_FRAC_BITS;

  typedef struct packed {
    logic        degen;
    logic [OW-1:0] nz;
    logic [OW-1:0] ny;
    logic [OW-1:0] nx;
  } normal_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [DW-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [3*OW-1:0] out_tdata;
  logic [0:0] out_tuser;

  normal_t normals_due[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;
  int mismatches = 0;
  int normals_seen = 0;
  int degen_seen = 0;
  int tris_sent = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  triangle_face_normal_unit_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  function automatic int bit_length(logic [63:0] v);
    int bl;
    bl = 0;
    for (int j = 0; j < 64; j++)
      if (v[j]) bl = j + 1;
    return bl;
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt = bt >> 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  function automatic normal_t face_normal(logic [DW-1:0] d);
    logic signed [63:0] p[9];
    logic signed [63:0] u[3], v[3], cr[3];
    logic [63:0] mg[3], q[3], sum, len, n, lim;
    logic ng[3];
    int top, sh;
    normal_t r;
    for (int i = 0; i < 9; i++)
      p[i] = {{(64-CW){d[i*CW+CW-1]}}, d[i*CW +: CW]};
    for (int i = 0; i < 3; i++) begin
      u[i] = p[6+i] - p[3+i];
      v[i] = p[i] - p[3+i];
    end
    cr[0] = u[1] * v[2] - u[2] * v[1];
    cr[1] = u[2] * v[0] - u[0] * v[2];
    cr[2] = u[0] * v[1] - u[1] * v[0];
    top = 0;
    for (int i = 0; i < 3; i++) begin
      ng[i] = cr[i] < 0;
      mg[i] = ng[i] ? -cr[i] : cr[i];
      if (bit_length(mg[i]) > top) top = bit_length(mg[i]);
    end
    r = '0;
    if (top == 0) begin
      r.degen = 1'b1;
      return r;
    end
    sh = top - 31;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      q[i] = (sh >= 0) ? (mg[i] >> sh) : (mg[i] << (-sh));
      sum = sum + q[i] * q[i];
    end
    len = floor_sqrt(sum);
    lim = 64'd1 << FB;
    if (lim > 64'd32767) lim = 64'd32767;
    for (int i = 0; i < 3; i++) begin
      n = ((q[i] << FB) + (len >> 1)) / len;
      if (n > lim) n = lim;
      if (ng[i]) n = -n;
      case (i)
        0: r.nx = n[OW-1:0];
        1: r.ny = n[OW-1:0];
        default: r.nz = n[OW-1:0];
      endcase
    end
    return r;
  endfunction

  function automatic logic [DW-1:0] pack_tri(int c[9]);
    logic [DW-1:0] d;
    d = '0;
    for (int i = 0; i < 9; i++) d[i*CW +: CW] = c[i][CW-1:0];
    return d;
  endfunction

  task automatic send_tri(logic [DW-1:0] d);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    normals_due = {normals_due, face_normal(d)};
    tris_sent++;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic go_quiet();
    in_tvalid <= 1'b0;
    while (normals_due.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  // receiver: random stalls, or a counted hold-off
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    normal_t want, got;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser, out_tdata};
      normals_seen++;
      if (got.degen) degen_seen++;
      if (normals_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected normal %h", got);
      end else begin
        want = normals_due.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("normal mismatch: expected x=%h y=%h z=%h d=%b, got x=%h y=%h z=%h d=%b",
                     want.nx, want.ny, want.nz, want.degen,
                     got.nx, got.ny, got.nz, got.degen);
        end
      end
    end
  end

  function automatic int rand_coord(int span);
    if (span == 0) return int'($urandom);
    return $urandom_range(2 * span) - span;
  endfunction

  task automatic test_directed();
    int c[9];
    int mx, mn;
    mx = (1 << (CW - 1)) - 1;
    mn = -(1 << (CW - 1));
    c = '{0, 0, 0, 0, 0, 0, 0, 0, 0};           // all coincident
    send_tri(pack_tri(c));
    c = '{1, 1, 1, 2, 2, 2, 3, 3, 3};           // collinear
    send_tri(pack_tri(c));
    c = '{256, 0, 0, 0, 0, 0, 0, 256, 0};       // axis-aligned normals
    send_tri(pack_tri(c));
    c = '{0, 256, 0, 0, 0, 0, 256, 0, 0};
    send_tri(pack_tri(c));
    c = '{0, 0, 256, 0, 0, 0, 0, 256, 0};
    send_tri(pack_tri(c));
    c = '{0, 256, 0, 0, 0, 0, 0, 0, 256};
    send_tri(pack_tri(c));
    c = '{1, 0, 0, 0, 0, 0, 0, 1, 0};           // tiny cross, left shift
    send_tri(pack_tri(c));
    c = '{mx, mn, mx, mn, mx, mn, mx, mx, mn};  // extremes, widest cross
    send_tri(pack_tri(c));
    c = '{mn, mn, mn, mx, mx, mx, mx, mn, mn};
    send_tri(pack_tri(c));
    c = '{mx, mx, mx, mx, mx, mx, mx, mx, mx};
    send_tri(pack_tri(c));
    c = '{mn, mn, mn, mn, mn, mn, mn, mn, mn};
    send_tri(pack_tri(c));
    c = '{mx, 0, 0, mn, 0, 0, mn, mx, 0};
    send_tri(pack_tri(c));
    c = '{-1, -1, -1, 0, 0, 0, 1, -1, 0};
    send_tri(pack_tri(c));
    c = '{3, 4, 0, 0, 0, 0, 0, 0, 5};
    send_tri(pack_tri(c));
    // whole-word bit patterns; any bits above the coordinate width must be ignored
    send_tri({DW{1'b1}});
    send_tri({(DW/2){2'b10}});
    go_quiet();
  endtask

  task automatic test_random(int count);
    int c[9];
    int span, k;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(9))
        0, 1, 2, 3: span = 0;
        4, 5: span = 1 << $urandom_range(20);
        6: span = $urandom_range(4);
        default: span = -1;
      endcase
      if (span < 0) begin
        // collinear or coincident: A and C along one direction from B
        for (int i = 0; i < 3; i++) begin
          c[3+i] = rand_coord(1 << 20);
          c[6+i] = $urandom_range(2000) - 1000;
        end
        k = $urandom_range(6) - 3;
        for (int i = 0; i < 3; i++) begin
          c[i] = c[3+i] + k * c[6+i];
          c[6+i] = c[3+i] + c[6+i];
        end
      end else begin
        for (int i = 0; i < 9; i++) c[i] = rand_coord(span);
      end
      send_tri(pack_tri(c));
    end
    go_quiet();
  endtask

  task automatic test_backpressure();
    int c[9];
    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(posedge clk);
    hold_cycles <= 300;
    for (int n = 0; n < 120; n++) begin
      for (int i = 0; i < 9; i++) c[i] = rand_coord(0);
      send_tri(pack_tri(c));
    end
    go_quiet();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 12;
    recv_idle_pct = 69;
    test_directed();
    test_random(120);
    send_idle_pct = 69;
    recv_idle_pct = 12;
    test_random(120);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(120);
    test_backpressure();
    $display("Sent %0d triangles, checked %0d normals (%0d degenerate),", tris_sent,
             normals_seen, degen_seen);
    $display("over three idle mixes and one long output stall.");
    if (mismatches == 0 && normals_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches, %0d normals missing", mismatches, normals_due.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("timeout waiting for normals");
    $display("FAILED: results differ");
    $finish;
  end
endmodule

>>> triangle_face_normal_unit_core.f
+incdir+rtl/core
rtl/core/tfn_pkg.sv
rtl/core/tfn_sqrt_pipe.sv
rtl/core/tfn_div_pipe.sv
rtl/core/triangle_face_normal_unit_core.sv
rtl/core/tfn_checker.sv
tb/testbench.sv
